@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the formatter RTL.
// Clock i_clk and active-low reset i_rst_n are taken from the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define UAF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define UAF_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);
`else
`define UAF_ASSERT(lbl, prop, msg)
`define UAF_NEVER(lbl, cond, msg)
`endif
`endif

@@ hw/rtl/uafmt_pkg.sv @@
// Package for the unsigned-to-ASCII formatter: job descriptor, codes, character tables.
// No dependencies.
package uafmt_pkg;

    localparam logic [1:0] CMD_DEC   = 2'd0;
    localparam logic [1:0] CMD_HEXLO = 2'd1;
    localparam logic [1:0] CMD_HEXUP = 2'd2;
    localparam logic [1:0] CMD_PTR   = 2'd3;

    localparam logic [4:0] DEC_DIGITS   = 5'd10;
    localparam logic [4:0] HEX32_DIGITS = 5'd8;
    localparam logic [4:0] HEX64_DIGITS = 5'd16;
    localparam logic [4:0] DD_STEPS     = 5'd31;
    localparam logic [2:0] NIL_LAST     = 3'd4;
    localparam logic [2:0] PFX_LAST     = 3'd1;

    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_X    = 8'h78;
    localparam logic [7:0] CH_LA   = 8'h61;
    localparam logic [7:0] CH_UA   = 8'h41;

    localparam int JOBQ_DEPTH = 2;
    localparam int JOBQ_AW    = $clog2(JOBQ_DEPTH);

    typedef struct packed {
        logic [63:0] digits;   // left-aligned nibbles, most significant first
        logic [4:0]  nmax;     // nibbles held in digits
        logic        upper;
        logic        prefix;
        logic        nil;
    } t_job;

    function automatic logic [7:0] nil_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h28;
            3'd1:    c = 8'h6e;
            3'd2:    c = 8'h69;
            3'd3:    c = 8'h6c;
            default: c = 8'h29;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = CH_ZERO + {4'd0, d};
        end else begin
            c = (upper ? CH_UA : CH_LA) + {4'd0, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

@@ hw/rtl/uafmt_front.sv @@
// Front end: accepts a number, converts decimal by shift-add-3, builds a job.
// Depends on uafmt_pkg and assert_macros.svh.
`include "assert_macros.svh"
module uafmt_front import uafmt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [1:0]  i_cmd,
    input  logic [63:0] i_value,
    input  logic        i_q_full,
    output logic        o_q_push,
    output t_job        o_q_job
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_CONV = 3'b010,
        F_PUSH = 3'b100
    } t_fstate;

    t_fstate     r_state, n_state;
    logic [31:0] r_bin, n_bin;
    logic [39:0] r_bcd, n_bcd;
    logic [39:0] adj;
    logic [4:0]  r_cnt, n_cnt;
    t_job        r_job, n_job;

    always_comb begin
        for (int i = 0; i < 10; i++) begin
            adj[4*i +: 4] = (r_bcd[4*i +: 4] >= 4'd5) ? r_bcd[4*i +: 4] + 4'd3
                                                      : r_bcd[4*i +: 4];
        end
    end

    always_comb begin
        n_state  = r_state;
        n_bin    = r_bin;
        n_bcd    = r_bcd;
        n_cnt    = r_cnt;
        n_job    = r_job;
        o_q_push = 1'b0;
        unique case (r_state)
            F_IDLE: begin
                if (i_push) begin
                    n_job.upper  = (i_cmd == CMD_HEXUP);
                    n_job.prefix = 1'b0;
                    n_job.nil    = 1'b0;
                    if (i_cmd == CMD_DEC) begin
                        n_bin   = i_value[31:0];
                        n_bcd   = '0;
                        n_cnt   = DD_STEPS;
                        n_state = F_CONV;
                    end else if (i_cmd == CMD_PTR) begin
                        n_job.digits = i_value;
                        n_job.nmax   = HEX64_DIGITS;
                        n_job.prefix = (i_value != 64'd0);
                        n_job.nil    = (i_value == 64'd0);
                        n_state      = F_PUSH;
                    end else begin
                        n_job.digits = {i_value[31:0], 32'd0};
                        n_job.nmax   = HEX32_DIGITS;
                        n_state      = F_PUSH;
                    end
                end
            end
            F_CONV: begin
                n_bin = {r_bin[30:0], 1'b0};
                n_bcd = {adj[38:0], r_bin[31]};
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    n_job.digits = {n_bcd, 24'd0};
                    n_job.nmax   = DEC_DIGITS;
                    n_state      = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_q_full) begin
                    o_q_push = 1'b1;
                    n_state  = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_bcd <= n_bcd;
        r_cnt <= n_cnt;
        r_job <= n_job;
    end

    assign o_full  = (r_state != F_IDLE);
    assign o_q_job = r_job;

    `UAF_ASSERT(a_push_only_when_ready, o_q_push |-> (r_state == F_PUSH && !i_q_full), "queue push outside push state")
    `UAF_ASSERT(a_conv_ends_in_push, (r_state == F_CONV && r_cnt == 5'd0) |=> (r_state == F_PUSH), "conversion did not finish")

endmodule

@@ hw/rtl/uafmt_jobq.sv @@
// Short job queue between front and back ends.
// Depends on uafmt_pkg and assert_macros.svh.
`include "assert_macros.svh"
module uafmt_jobq import uafmt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    output logic o_full,
    input  logic i_pop,
    output t_job o_data,
    output logic o_empty
);

    t_job               r_mem [JOBQ_DEPTH];
    logic [JOBQ_AW:0]   r_wp, r_rp;

    assign o_empty = (r_wp == r_rp);
    assign o_full  = (r_wp[JOBQ_AW] != r_rp[JOBQ_AW]) &&
                     (r_wp[JOBQ_AW-1:0] == r_rp[JOBQ_AW-1:0]);
    assign o_data  = r_mem[r_rp[JOBQ_AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wp <= r_wp + (JOBQ_AW+1)'(1);
            end
            if (i_pop && !o_empty) begin
                r_rp <= r_rp + (JOBQ_AW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wp[JOBQ_AW-1:0]] <= i_data;
        end
    end

    `UAF_NEVER(a_no_push_when_full, i_push && o_full, "job pushed into full queue")

endmodule

@@ hw/rtl/uafmt_back.sv @@
// Back end: takes jobs, skips leading zeros and emits one character per transfer.
// Depends on uafmt_pkg and assert_macros.svh.
`include "assert_macros.svh"
module uafmt_back import uafmt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_empty,
    input  t_job       i_q_job,
    output logic       o_q_pop,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [7:0] o_ascii_char,
    output logic       o_last,
    output logic [4:0] o_char_count
);

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_PRE  = 4'b0010,
        B_SKIP = 4'b0100,
        B_DIG  = 4'b1000
    } t_bstate;

    t_bstate     r_state, n_state;
    logic [63:0] r_dig, n_dig;
    logic [4:0]  r_left, n_left;
    logic [4:0]  r_emit, n_emit;
    logic [2:0]  r_idx, n_idx;
    logic        r_upper, n_upper;
    logic        r_nil, n_nil;
    logic        r_ov, n_ov;
    logic [7:0]  r_char, n_char;
    logic        r_last, n_last;
    logic [4:0]  r_cnt, n_cnt;
    logic        adv;
    logic        emit;

    assign adv = !r_ov || i_pop;

    always_comb begin
        n_state = r_state;
        n_dig   = r_dig;
        n_left  = r_left;
        n_emit  = r_emit;
        n_idx   = r_idx;
        n_upper = r_upper;
        n_nil   = r_nil;
        n_char  = r_char;
        n_last  = r_last;
        n_cnt   = r_cnt;
        emit    = 1'b0;
        o_q_pop = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_dig   = i_q_job.digits;
                    n_left  = i_q_job.nmax;
                    n_upper = i_q_job.upper;
                    n_nil   = i_q_job.nil;
                    n_emit  = 5'd0;
                    n_idx   = 3'd0;
                    n_state = (i_q_job.nil || i_q_job.prefix) ? B_PRE : B_SKIP;
                end
            end
            B_PRE: begin
                if (adv) begin
                    emit   = 1'b1;
                    n_char = r_nil ? nil_char(r_idx) : ((r_idx == 3'd0) ? CH_ZERO : CH_X);
                    n_last = r_nil && (r_idx == NIL_LAST);
                    n_cnt  = n_last ? r_emit + 5'd1 : 5'd0;
                    n_emit = r_emit + 5'd1;
                    n_idx  = r_idx + 3'd1;
                    if (r_nil && r_idx == NIL_LAST) begin
                        n_state = B_IDLE;
                    end else if (!r_nil && r_idx == PFX_LAST) begin
                        n_state = B_SKIP;
                    end
                end
            end
            B_SKIP: begin
                if (r_dig[63:60] == 4'd0 && r_left > 5'd1) begin
                    n_dig  = {r_dig[59:0], 4'd0};
                    n_left = r_left - 5'd1;
                end else begin
                    n_state = B_DIG;
                end
            end
            B_DIG: begin
                if (adv) begin
                    emit   = 1'b1;
                    n_char = digit_char(r_dig[63:60], r_upper);
                    n_last = (r_left == 5'd1);
                    n_cnt  = n_last ? r_emit + 5'd1 : 5'd0;
                    n_emit = r_emit + 5'd1;
                    n_dig  = {r_dig[59:0], 4'd0};
                    n_left = r_left - 5'd1;
                    if (r_left == 5'd1) begin
                        n_state = B_IDLE;
                    end
                end
            end
            default: n_state = B_IDLE;
        endcase
        if (emit) begin
            n_ov = 1'b1;
        end else if (i_pop) begin
            n_ov = 1'b0;
        end else begin
            n_ov = r_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dig   <= n_dig;
        r_left  <= n_left;
        r_emit  <= n_emit;
        r_idx   <= n_idx;
        r_upper <= n_upper;
        r_nil   <= n_nil;
        r_char  <= n_char;
        r_last  <= n_last;
        r_cnt   <= n_cnt;
    end

    assign o_empty      = !r_ov;
    assign o_ascii_char = r_char;
    assign o_last       = r_last;
    assign o_char_count = r_cnt;

    `UAF_ASSERT(a_last_has_count, (r_ov && r_last) |-> (r_cnt != 5'd0 && r_cnt <= 5'd18), "bad count on last")
    `UAF_NEVER(a_dig_left_nonzero, r_state == B_DIG && r_left == 5'd0, "digit state with nothing left")

endmodule

@@ hw/rtl/unsigned_to_ascii_formatter_core.sv @@
// Top level of the unsigned-to-ASCII formatter: front end, job queue, back end.
// Depends on uafmt_pkg, uafmt_front, uafmt_jobq, uafmt_back.
//
//  channel  | handshake      | payload
//  ---------+----------------+-----------------------------------------
//  input    | push / full    | i_cmd[1:0], i_value[63:0]
//  result   | pop / empty    | o_ascii_char[7:0], o_last, o_char_count[4:0]
//
// Decimal items run the shift-add-3 loop in the front end (32 steps); hex and
// pointer items go straight to the push state. The back end loads a job, skips
// leading zero nibbles one at a time, then moves on to the first digit (not for
// "(nil)") and emits one character per transfer.
// Front and back overlap through a two-entry job queue; either side stalls alone.
// Synchronous active-low reset empties the queue and the result register.
module unsigned_to_ascii_formatter_core import uafmt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_cmd,
    input  logic [63:0] i_value,
    input  logic        pop,
    output logic        empty,
    output logic [7:0]  o_ascii_char,
    output logic        o_last,
    output logic [4:0]  o_char_count
);

    logic q_push, q_full, q_pop, q_empty;
    t_job q_wjob, q_rjob;

    uafmt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_full   (full),
        .i_cmd    (i_cmd),
        .i_value  (i_value),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_job  (q_wjob)
    );

    uafmt_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wjob),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rjob),
        .o_empty (q_empty)
    );

    uafmt_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_q_job      (q_rjob),
        .o_q_pop      (q_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_ascii_char (o_ascii_char),
        .o_last       (o_last),
        .o_char_count (o_char_count)
    );

endmodule

@@ sim/unsigned_to_ascii_formatter_core_tb.sv @@
// Self-checking testbench for unsigned_to_ascii_formatter_core: drives directed numbers, then numbers with random
// formats, all with random gaps, predicts each character run, and checks every result transfer.
// Depends on uafmt_pkg and the formatter RTL.
module unsigned_to_ascii_formatter_core_tb;
    import uafmt_pkg::*;

    localparam int RANDOM_NUMBERS = 80;
    localparam int HOLD_CYCLES    = 300;
    localparam int STALL_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int N_DIRECTED     = 21;

    localparam logic [65:0] DIRECTED [N_DIRECTED] = '{
        {CMD_DEC,   64'd0},
        {CMD_DEC,   64'd1},
        {CMD_DEC,   64'd9},
        {CMD_DEC,   64'd10},
        {CMD_DEC,   64'd1000000000},
        {CMD_DEC,   64'h0000_0000_FFFF_FFFF},
        {CMD_DEC,   64'hFFFF_FFFF_0000_0000},
        {CMD_DEC,   64'hDEAD_BEEF_0000_007B},
        {CMD_HEXLO, 64'd0},
        {CMD_HEXLO, 64'h0000_0000_FFFF_FFFF},
        {CMD_HEXLO, 64'h0123_4567_89AB_CDEF},
        {CMD_HEXLO, 64'hFFFF_FFFF_0000_0000},
        {CMD_HEXUP, 64'd0},
        {CMD_HEXUP, 64'h0000_0000_00AB_CDEF},
        {CMD_HEXUP, 64'hFEDC_BA98_FFFF_FFFF},
        {CMD_PTR,   64'd0},
        {CMD_PTR,   64'd1},
        {CMD_PTR,   64'hFFFF_FFFF_FFFF_FFFF},
        {CMD_PTR,   64'h8000_0000_0000_0000},
        {CMD_PTR,   64'h0000_0001_0000_0000},
        {CMD_PTR,   64'h0123_4567_89AB_CDEF}
    };

    typedef struct {
        logic [7:0] ch;
        logic       last;
        logic [4:0] count;
    } t_char_item;

    class char_run_board;
        t_char_item pending_chars[$];
        int         checked;
        int         failures;
        int         numbers;
        int         per_mode[4];

        function void note_number(logic [1:0] cmd, logic [63:0] value);
            logic [7:0] text[$];
            logic [63:0] v;
            logic [3:0] nib;
            logic       upper;
            string      nil_s;
            t_char_item item;
            int         n;
            nil_s = "(nil)";
            numbers++;
            per_mode[cmd]++;
            if (cmd == CMD_DEC) begin
                v = {32'd0, value[31:0]};
                do begin
                    text.push_front("0" + 8'(v % 64'd10));
                    v = v / 64'd10;
                end while (v != 64'd0);
            end else if (cmd == CMD_PTR && value == 64'd0) begin
                for (int k = 0; k < nil_s.len(); k++) text.push_back(nil_s[k]);
            end else begin
                v = (cmd == CMD_PTR) ? value : {32'd0, value[31:0]};
                upper = (cmd == CMD_HEXUP);
                do begin
                    nib = v[3:0];
                    if (nib < 4'd10) begin
                        text.push_front("0" + 8'(nib));
                    end else begin
                        text.push_front((upper ? "A" : "a") + 8'(nib) - 8'd10);
                    end
                    v = v >> 4;
                end while (v != 64'd0);
                if (cmd == CMD_PTR) begin
                    text.push_front("x");
                    text.push_front("0");
                end
            end
            n = text.size();
            for (int k = 0; k < n; k++) begin
                item.ch    = text[k];
                item.last  = (k == n - 1);
                item.count = item.last ? 5'(n) : 5'd0;
                pending_chars.push_back(item);
            end
        endfunction

        function void check_char(logic [7:0] ch, logic last, logic [4:0] count);
            t_char_item exp;
            checked++;
            if (pending_chars.size() == 0) begin
                $error("unexpected result: ascii_char %h last %b char_count %0d", ch, last, count);
                failures++;
                return;
            end
            exp = pending_chars.pop_front();
            if (ch !== exp.ch) begin
                $error("ascii_char: expected %h, actual %h", exp.ch, ch);
                failures++;
            end
            if (last !== exp.last) begin
                $error("last: expected %b, actual %b", exp.last, last);
                failures++;
            end
            if (count !== exp.count) begin
                $error("char_count: expected %0d, actual %0d", exp.count, count);
                failures++;
            end
        endfunction
    endclass

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push    = 1'b0;
    logic        full;
    logic [1:0]  i_cmd   = CMD_DEC;
    logic [63:0] i_value = 64'd0;
    logic        pop     = 1'b0;
    logic        empty;
    logic [7:0]  o_ascii_char;
    logic        o_last;
    logic [4:0]  o_char_count;

    char_run_board board = new();
    int          full_stalls = 0;

    unsigned_to_ascii_formatter_core u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_cmd        (i_cmd),
        .i_value      (i_value),
        .pop          (pop),
        .empty        (empty),
        .o_ascii_char (o_ascii_char),
        .o_last       (o_last),
        .o_char_count (o_char_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int idle_draw(bit burst);
        return burst ? 0 : $urandom_range(0, 6);
    endfunction

    // Entered and left just after a falling edge.
    task automatic send_number(input logic [1:0] cmd, input logic [63:0] value, input int gap);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push    <= 1'b1;
        i_cmd   <= cmd;
        i_value <= value;
        do @(posedge i_clk); while (full);
        board.note_number(cmd, value);
        @(negedge i_clk);
    endtask

    function automatic logic [63:0] random_value();
        logic [63:0] v;
        int          sel;
        sel = $urandom_range(0, 9);
        v   = {$urandom(), $urandom()};
        if (sel == 0) begin
            v = 64'd0;
        end else if (sel > 3) begin
            v = v >> $urandom_range(0, 63);
        end
        return v;
    endfunction

    // Result side: random pop gaps, idle-free bursts, and one long hold-off.
    initial begin
        int  gap;
        int  hold_at;
        bit  hold_done;
        hold_at   = $urandom_range(150, 300);
        hold_done = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            gap = idle_draw((board.checked / 48) % 4 == 3);
            if (!hold_done && board.checked >= hold_at) begin
                gap       = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            board.check_char(o_ascii_char, o_last, o_char_count);
            @(negedge i_clk);
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (push && full) full_stalls++;
            if ((push && !full) || (pop && !empty)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("Verification failed");
        $finish;
    end

    initial begin
        logic [1:0]  cmd;
        logic [63:0] value;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int k = 0; k < N_DIRECTED; k++) begin
            send_number(DIRECTED[k][65:64], DIRECTED[k][63:0], idle_draw(1'b0));
        end
        for (int k = 0; k < RANDOM_NUMBERS; k++) begin
            cmd   = 2'($urandom_range(0, 3));
            value = random_value();
            send_number(cmd, value, idle_draw((k / 20) % 3 == 2));
        end
        push <= 1'b0;
        while (board.pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Formatted %0d numbers (dec %0d, hex lower %0d, hex upper %0d, pointer %0d)",
                 board.numbers, board.per_mode[CMD_DEC], board.per_mode[CMD_HEXLO],
                 board.per_mode[CMD_HEXUP], board.per_mode[CMD_PTR]);
        $display("Checked %0d characters; input held off by full for %0d cycles",
                 board.checked, full_stalls);
        if (board.failures == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
